// ===== rtl/btm_pkg.sv =====
`timescale 1ns / 1ps

package btm_pkg;

  localparam int unsigned WIDTH_REG_W = 8;
  localparam int unsigned MASK_REG_W  = 20;
  localparam int unsigned COUNT_W     = 14;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned IN_DATA_W   = 8;
  localparam int unsigned OUT_DATA_W  = 32;

  localparam logic [COUNT_W-1:0]     COUNT_MAX         = '1;
  localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET       = 8'd96;
  localparam logic [MASK_REG_W-1:0]  MASK_TOP_RESET    = 20'd262144;
  localparam logic [MASK_REG_W-1:0]  MASK_MIDDLE_RESET = 20'd923745;
  localparam logic [MASK_REG_W-1:0]  MASK_BOTTOM_RESET = 20'd74898;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH = 2'd0,
    CFG_MASK_TOP    = 2'd1,
    CFG_MASK_MIDDLE = 2'd2,
    CFG_MASK_BOTTOM = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic top;
    logic mid;
    logic bot;
  } btm_bits_t;

endpackage

// ===== rtl/btm_cell.sv =====
`timescale 1ns / 1ps

module btm_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              shift_en,
  input  btm_pkg::btm_bits_t d,
  input  btm_pkg::btm_bits_t mask,
  output btm_pkg::btm_bits_t q,
  output logic              ok
);
  import btm_pkg::*;

  btm_bits_t q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else if (shift_en) begin
      q_r <= d;
    end
  end

  assign q  = q_r;
  // The column passes when every required pixel is set after the shift.
  assign ok = &(logic'(d.top | ~mask.top) & logic'(d.mid | ~mask.mid)
                & logic'(d.bot | ~mask.bot));

endmodule

// ===== rtl/btm_line_store.sv =====
`timescale 1ns / 1ps

module btm_line_store #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = 7
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [1:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [1:0]    rd_data,
  output logic [1:0]    rd_zero_data
);

  logic [1:0] mem [DEPTH];
  logic [1:0] rd_data_r;
  logic [1:0] rd_zero_r;

  // Two read ports: the next column and column zero for a frame start.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= (wr_en && (wr_addr == rd_addr)) ? wr_data : mem[rd_addr];
    rd_zero_r <= (wr_en && (wr_addr == AW'(0))) ? wr_data : mem[AW'(0)];
  end

  assign rd_data      = rd_data_r;
  assign rd_zero_data = rd_zero_r;

endmodule

// ===== rtl/binary_template_match_counter.sv =====
`timescale 1ns / 1ps
// A result word is registered and appears in the cycle after its input word is accepted.
// Throughput: one word per cycle while out_tready holds; the output register is refilled
// in the cycle it is taken, and the column read for the next word is fetched ahead.
// Reset (rst_n low, synchronous) clears position, windows, counts and output valid and
// reloads the config defaults; the line store is not cleared and holds no valid state.

module binary_template_match_counter #(
  parameter int unsigned MAX_WIDTH  = 128,
  parameter int unsigned MASK_WIDTH = 20
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [btm_pkg::IN_DATA_W-1:0]     in_tdata,   // pixel
  input  logic                              in_tuser,   // frame_start
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [btm_pkg::OUT_DATA_W-1:0]    out_tdata,  // window_match, match_count, set_count
  input  logic                              cfg_wen,
  input  logic [btm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [btm_pkg::MASK_REG_W-1:0]    cfg_wdata
);
  import btm_pkg::*;

  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned WW = (AW + 1 > WIDTH_REG_W) ? AW + 1 : WIDTH_REG_W;
  localparam int unsigned SW = $clog2(MASK_WIDTH + 1);
  localparam logic [1:0]  ROWS_FULL = 2'd2;

  function automatic logic [WW-1:0] clamp_width(input logic [WIDTH_REG_W-1:0] w);
    logic [WW-1:0] e;
    e = WW'(w);
    if (e == '0) begin
      e = WW'(1);
    end else if (e > WW'(MAX_WIDTH)) begin
      e = WW'(MAX_WIDTH);
    end
    return e;
  endfunction

  logic [WW-1:0]         width_r;
  logic [MASK_REG_W-1:0] mask_top_r;
  logic [MASK_REG_W-1:0] mask_mid_r;
  logic [MASK_REG_W-1:0] mask_bot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= clamp_width(WIDTH_RESET);
      mask_top_r <= MASK_TOP_RESET;
      mask_mid_r <= MASK_MIDDLE_RESET;
      mask_bot_r <= MASK_BOTTOM_RESET;
    end else if (cfg_wen) begin
      case (cfg_idx_t'(cfg_index))
        CFG_IMAGE_WIDTH: width_r    <= clamp_width(cfg_wdata[WIDTH_REG_W-1:0]);
        CFG_MASK_TOP:    mask_top_r <= cfg_wdata;
        CFG_MASK_MIDDLE: mask_mid_r <= cfg_wdata;
        CFG_MASK_BOTTOM: mask_bot_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [AW-1:0]      col_r, col, col_nxt;
  logic [1:0]         rows_r, rows, rows_nxt;
  logic [SW-1:0]      skip_r, skip, skip_nxt;
  logic [COUNT_W-1:0] match_r, match_cur, match_nxt;
  logic [COUNT_W-1:0] set_r, set_cur, set_nxt;
  logic               out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic       accept, px, fs, hit, in_win, row_end, all_ok;
  logic [1:0] rd_col, rd_zero, above;
  btm_bits_t  head;
  btm_bits_t  cell_d    [MASK_WIDTH];
  btm_bits_t  cell_q    [MASK_WIDTH];
  btm_bits_t  cell_mask [MASK_WIDTH];
  logic [MASK_WIDTH-1:0] cell_ok;

  assign in_tready = rst_n && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;
  assign px        = in_tdata[0];
  assign fs        = in_tuser;

  assign above     = fs ? rd_zero : rd_col;
  assign col       = fs ? '0 : col_r;
  assign rows      = fs ? '0 : rows_r;
  assign skip      = fs ? '0 : skip_r;
  assign match_cur = fs ? '0 : match_r;
  assign set_cur   = fs ? '0 : set_r;
  assign head      = '{top: above[1], mid: above[0], bot: px};

  btm_line_store #(
    .DEPTH(MAX_WIDTH),
    .AW   (AW)
  ) u_line_store (
    .clk         (clk),
    .wr_en       (accept),
    .wr_addr     (col),
    .wr_data     ({above[0], px}),
    .rd_addr     (accept ? col_nxt : col_r),
    .rd_data     (rd_col),
    .rd_zero_data(rd_zero)
  );

  for (genvar i = 0; i < MASK_WIDTH; i++) begin : g_cell
    if (i == MASK_WIDTH - 1) begin : g_head
      assign cell_d[i] = head;
    end else begin : g_body
      assign cell_d[i] = fs ? '0 : cell_q[i+1];
    end
    if (i < MASK_REG_W) begin : g_mask
      assign cell_mask[i] = '{top: mask_top_r[i], mid: mask_mid_r[i], bot: mask_bot_r[i]};
    end else begin : g_nomask
      assign cell_mask[i] = '0;
    end
    btm_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .shift_en(accept),
      .d       (cell_d[i]),
      .mask    (cell_mask[i]),
      .q       (cell_q[i]),
      .ok      (cell_ok[i])
    );
  end

  assign all_ok  = &cell_ok;
  assign in_win  = (rows == ROWS_FULL) && (WW'(col) >= WW'(MASK_WIDTH - 1));
  assign row_end = (WW'(col) + WW'(1)) >= width_r;
  assign set_nxt = (px && (set_cur != COUNT_MAX)) ? set_cur + COUNT_W'(1) : set_cur;

  always_comb begin
    hit       = 1'b0;
    skip_nxt  = skip;
    match_nxt = match_cur;
    if (in_win) begin
      if (skip != '0) begin
        skip_nxt = skip - SW'(1);
      end else if (all_ok) begin
        hit      = 1'b1;
        skip_nxt = SW'(MASK_WIDTH);
        if (match_cur != COUNT_MAX) begin
          match_nxt = match_cur + COUNT_W'(1);
        end
      end
    end
    if (row_end) begin
      col_nxt  = '0;
      skip_nxt = '0;
      rows_nxt = (rows == ROWS_FULL) ? rows : rows + 2'd1;
    end else begin
      col_nxt  = col + AW'(1);
      rows_nxt = rows;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      rows_r      <= '0;
      skip_r      <= '0;
      match_r     <= '0;
      set_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        col_r   <= col_nxt;
        rows_r  <= rows_nxt;
        skip_r  <= skip_nxt;
        match_r <= match_nxt;
        set_r   <= set_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= OUT_DATA_W'({set_nxt, match_nxt, hit});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== rtl/btm_checker.sv =====
`timescale 1ns / 1ps

module btm_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic [btm_pkg::IN_DATA_W-1:0]  in_tdata,
  input logic                           in_tuser,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [btm_pkg::OUT_DATA_W-1:0] out_tdata
);
  import btm_pkg::*;

  logic in_acc;
  assign in_acc = in_tvalid && in_tready;

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_tvalid)
    else $error("accepted word gave no result word");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result word changed");

  a_frame_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tuser |=> !out_tdata[0] && (out_tdata[14:1] == '0)
      && (out_tdata[28:15] == COUNT_W'($past(in_tdata[0]))))
    else $error("frame start did not restart the counts");

  a_match_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[14:1] != '0)
    else $error("match flagged with a zero match count");

endmodule

bind binary_template_match_counter btm_checker u_btm_checker (.*);
